>>> rtl/stereo_peak_to_peak_level_meter_core_macros.svh
// Assertion helpers for the checker file.
`ifndef STEREO_PEAK_TO_PEAK_LEVEL_METER_CORE_MACROS_SVH
`define STEREO_PEAK_TO_PEAK_LEVEL_METER_CORE_MACROS_SVH

// Property checked only outside reset.
`define SP2P_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every edge, reset included.
`define SP2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sp2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sp2p_pkg;

    localparam int LEVEL_W  = 3;
    localparam int SPEED_W  = 9;
    localparam int ACTION_W = 2;
    localparam int LADDER_W = 12;
    localparam int LADDER_N = 7;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BOTH   = 2'd2;

    // half-octave range thresholds, ascending
    localparam logic [LADDER_W-1:0] LADDER [LADDER_N] = '{
        12'd256, 12'd362, 12'd512, 12'd724, 12'd1024, 12'd1448, 12'd2048
    };

    typedef struct packed {
        logic en;     // item leaves the input stage this cycle
        logic take;   // item carries a sample pair
        logic clear;  // item carries a window tick
    } sp2p_trk_ctl_t;

    // 300 / (level + 1)
    function automatic logic [SPEED_W-1:0] speed_of(input logic [LEVEL_W-1:0] lvl);
        logic [SPEED_W-1:0] spd;
        case (lvl)
            3'd0:    spd = 9'd300;
            3'd1:    spd = 9'd150;
            3'd2:    spd = 9'd100;
            3'd3:    spd = 9'd75;
            3'd4:    spd = 9'd60;
            3'd5:    spd = 9'd50;
            3'd6:    spd = 9'd42;
            3'd7:    spd = 9'd37;
            default: spd = 9'd300;
        endcase
        return spd;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sp2p_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Min/max tracker for one channel; range reflects the current item's sample.
module sp2p_tracker
    import sp2p_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sp2p_trk_ctl_t          ctl,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic      [SAMPLE_BITS-1:0] range
);

    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [SAMPLE_BITS-1:0] high_reg, high_next;

    always_comb begin
        low_next  = (ctl.take && (sample < low_reg))  ? sample : low_reg;
        high_next = (ctl.take && (sample > high_reg)) ? sample : high_reg;
        range     = (low_next < high_next) ? (high_next - low_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '1;
            high_reg <= '0;
        end else if (ctl.en) begin
            if (ctl.clear) begin
                low_reg  <= '1;
                high_reg <= '0;
            end else begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sp2p_quant.sv
`timescale 1ns / 1ps
`default_nettype none

// Threshold ladder for both channels plus speed lookup on the right level.
module sp2p_quant
    import sp2p_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic [SAMPLE_BITS-1:0] left_range,
    input  wire logic [SAMPLE_BITS-1:0] right_range,
    output logic      [LEVEL_W-1:0]     left_level,
    output logic      [LEVEL_W-1:0]     right_level,
    output logic      [SPEED_W-1:0]     pixel_speed
);

    always_comb begin
        left_level  = '0;
        right_level = '0;
        for (int i = 0; i < LADDER_N; i++) begin
            if (left_range >= SAMPLE_BITS'(LADDER[i])) begin
                left_level = LEVEL_W'(i + 1);
            end
            if (right_range >= SAMPLE_BITS'(LADDER[i])) begin
                right_level = LEVEL_W'(i + 1);
            end
        end
        pixel_speed = speed_of(right_level);
    end

endmodule

`default_nettype wire

>>> rtl/stereo_peak_to_peak_level_meter_core.sv
// A tick moves from the input register through one level of tracker/ladder
//   logic into the result register, which acts as the output buffer and
//   offers it on m_*. Throughput: one transfer per cycle unless a tick waits
//   on a full result register with m_ready low. Reset: synchronous, active
//   low; trackers return to min = all ones, max = 0, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_to_peak_level_meter_core
    import sp2p_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [ACTION_W-1:0]    s_action,
    input  wire logic [SAMPLE_BITS-1:0] s_left_sample,
    input  wire logic [SAMPLE_BITS-1:0] s_right_sample,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [LEVEL_W-1:0]     m_left_level,
    output logic      [LEVEL_W-1:0]     m_right_level,
    output logic      [SPEED_W-1:0]     m_pixel_speed
);

    // ------------------------------------------------------------------
    // Input stage: captures one transfer per cycle while s_ready is high.
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [ACTION_W-1:0]    in_action_reg;
    logic [SAMPLE_BITS-1:0] in_left_reg;
    logic [SAMPLE_BITS-1:0] in_right_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     out_left_level_reg;
    logic [LEVEL_W-1:0]     out_right_level_reg;
    logic [SPEED_W-1:0]     out_speed_reg;

    logic                   in_take;
    logic                   in_tick;
    logic                   advance;
    sp2p_trk_ctl_t          trk_ctl;

    logic [SAMPLE_BITS-1:0] left_range;
    logic [SAMPLE_BITS-1:0] right_range;
    logic [LEVEL_W-1:0]     left_level;
    logic [LEVEL_W-1:0]     right_level;
    logic [SPEED_W-1:0]     pixel_speed;

    // Action decode: anything but a pure tick carries samples, anything but a
    // pure sample carries a tick (the unused code behaves like sample+tick).
    assign in_take = (in_action_reg != ACT_TICK);
    assign in_tick = (in_action_reg != ACT_SAMPLE);

    // A sample-only item never needs the result register, so it always moves.
    // A tick moves when the result register is free or being drained now.
    assign advance = in_valid_reg && (!in_tick || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        trk_ctl.en    = advance;
        trk_ctl.take  = in_take;
        trk_ctl.clear = in_tick;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_left_reg   <= s_left_sample;
            in_right_reg  <= s_right_sample;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel min/max trackers; range includes the current sample so a
    // combined sample+tick item is folded in before the window closes.
    // ------------------------------------------------------------------
    sp2p_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_trk_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (trk_ctl),
        .sample  (in_left_reg),
        .range   (left_range)
    );

    sp2p_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_trk_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (trk_ctl),
        .sample  (in_right_reg),
        .range   (right_range)
    );

    // Level ladder and animation speed.
    sp2p_quant #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_quant (
        .left_range  (left_range),
        .right_range (right_range),
        .left_level  (left_level),
        .right_level (right_level),
        .pixel_speed (pixel_speed)
    );

    // ------------------------------------------------------------------
    // Result register: loaded by a tick, emptied by a downstream transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_tick) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_tick) begin
            out_left_level_reg  <= left_level;
            out_right_level_reg <= right_level;
            out_speed_reg       <= pixel_speed;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_level  = out_left_level_reg;
    assign m_right_level = out_right_level_reg;
    assign m_pixel_speed = out_speed_reg;

endmodule

`default_nettype wire

>>> rtl/sp2p_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_peak_to_peak_level_meter_core_macros.svh"

module sp2p_checker
    import sp2p_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [LEVEL_W-1:0] m_left_level,
    input wire logic [LEVEL_W-1:0] m_right_level,
    input wire logic [SPEED_W-1:0] m_pixel_speed
);

    `SP2P_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `SP2P_ASSERT_RUN(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_left_level) && $stable(m_right_level) && $stable(m_pixel_speed), "stalled result changed")

    `SP2P_ASSERT_RUN(a_no_stall, aclk, aresetn, m_ready |-> s_ready, "input stalled with sink ready")

    `SP2P_ASSERT_RUN(a_speed_top, aclk, aresetn, m_valid && (m_right_level == 3'd0) |-> (m_pixel_speed == 9'd300), "speed mismatch at level zero")

    `SP2P_ASSERT_RUN(a_speed_low, aclk, aresetn, m_valid && (m_right_level == 3'd7) |-> (m_pixel_speed == 9'd37), "speed mismatch at level seven")

endmodule

bind stereo_peak_to_peak_level_meter_core sp2p_checker u_sp2p_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_level  (m_left_level),
    .m_right_level (m_right_level),
    .m_pixel_speed (m_pixel_speed)
);

`default_nettype wire
